// ===== design/tlptm_pkg.sv =====
`default_nettype none

package tlptm_pkg;

  // Field widths and address split of the two-level map.
  localparam int ADDR_W            = 32;
  localparam int FLAG_W            = 8;
  localparam int IDX_W             = 10;
  localparam int USED_W            = 5;
  localparam int DIR_SHIFT         = 22;
  localparam int PAGE_SHIFT        = 12;
  localparam int DIR_ENTRIES       = 1024;
  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int MAX_TABLES_DEF    = 16;

  localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hFFFF_F000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;   // clear one directory entry during the start-up pass
    logic capture;      // register the incoming request
    logic dir_read;     // read the directory entry of the held request
    logic decide;       // act on the directory entry (hit, allocate or pool full)
    logic wipe_step;    // zero one entry of the freshly allocated table
    logic finish;       // write the table entry (unless the pool is full) and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic present;
    logic pool_avail;
    logic wipe_last;
    logic clear_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== design/tlptm_ctrl.sv =====
`default_nettype none

module tlptm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tlptm_pkg::status_t st,
  output tlptm_pkg::cmd_t         cmd
);
  import tlptm_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_DECIDE = 6'b001000,
    S_WIPE   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.dir_read = 1'b1;
        state_next   = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!st.present && st.pool_avail) begin
          state_next = S_WIPE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WIPE: begin
        cmd.wipe_step = 1'b1;
        if (st.wipe_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/tlptm_datapath.sv =====
`default_nettype none

module tlptm_datapath #(
  parameter int MAX_TABLES = tlptm_pkg::MAX_TABLES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [tlptm_pkg::ADDR_W-1:0]      cfg_data,
  input  wire logic [tlptm_pkg::ADDR_W-1:0]      virt_addr,
  input  wire logic [tlptm_pkg::ADDR_W-1:0]      phys_addr,
  input  wire logic [tlptm_pkg::FLAG_W-1:0]      entry_flags,
  input  wire tlptm_pkg::cmd_t                   cmd,
  output tlptm_pkg::status_t                     st,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [tlptm_pkg::IDX_W-1:0]            dir_index,
  output logic [tlptm_pkg::IDX_W-1:0]            table_index,
  output logic [tlptm_pkg::ADDR_W-1:0]           table_addr,
  output logic                                   new_table,
  output logic [tlptm_pkg::ADDR_W-1:0]           entry_value,
  output logic [tlptm_pkg::USED_W-1:0]           tables_used,
  output logic                                   pool_full
);
  import tlptm_pkg::*;

  localparam int SLOT_W    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int CNT_W     = $clog2(MAX_TABLES + 1);
  localparam int TAB_AW    = SLOT_W + IDX_W;
  localparam int TAB_DEPTH = MAX_TABLES * ENTRIES_PER_TABLE;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TABLES);

  // Configuration and the held request.
  logic [ADDR_W-1:0] pool_base;
  logic [ADDR_W-1:0] va;
  logic [ADDR_W-1:0] pa;
  logic [FLAG_W-1:0] fl;

  // Allocation state and per-request results.
  logic [CNT_W-1:0]  counter;
  logic [SLOT_W-1:0] slot;
  logic              fresh;
  logic              full;
  logic [IDX_W-1:0]  wipe_idx;
  logic [IDX_W-1:0]  clr_idx;

  // Directory memory: present bit above the slot number.
  logic [SLOT_W:0]   dir_mem [DIR_ENTRIES];
  logic [SLOT_W:0]   dir_rdata;

  // Page table store; only written, one entry a cycle.
  logic [ADDR_W-1:0] table_mem [TAB_DEPTH];

  logic [IDX_W-1:0]  di;
  logic [IDX_W-1:0]  ti;
  logic [ADDR_W-1:0] entry_val;
  logic [ADDR_W-1:0] slot_offset;
  logic              alloc;

  assign di          = va[DIR_SHIFT +: IDX_W];
  assign ti          = va[PAGE_SHIFT +: IDX_W];
  assign entry_val   = pa | {{(ADDR_W-FLAG_W){1'b0}}, fl};
  assign slot_offset = {{(ADDR_W-SLOT_W-PAGE_SHIFT){1'b0}}, slot, {PAGE_SHIFT{1'b0}}};
  assign alloc       = cmd.decide & ~dir_rdata[SLOT_W] & st.pool_avail;

  assign st.present    = dir_rdata[SLOT_W];
  assign st.pool_avail = (counter < CNT_MAX);
  assign st.wipe_last  = (wipe_idx == IDX_W'(ENTRIES_PER_TABLE - 1));
  assign st.clear_last = (clr_idx == IDX_W'(DIR_ENTRIES - 1));
  assign st.out_busy   = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_we) begin
      pool_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      va <= virt_addr;
      pa <= phys_addr;
      fl <= entry_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      clr_idx <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (alloc) begin
        counter <= counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (dir_rdata[SLOT_W]) begin
        slot  <= dir_rdata[SLOT_W-1:0];
        fresh <= 1'b0;
        full  <= 1'b0;
      end else if (st.pool_avail) begin
        slot  <= SLOT_W'(counter);
        fresh <= 1'b1;
        full  <= 1'b0;
      end else begin
        fresh <= 1'b0;
        full  <= 1'b1;
      end
      wipe_idx <= '0;
    end else if (cmd.wipe_step) begin
      wipe_idx <= wipe_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      dir_mem[clr_idx] <= '0;
    end else if (alloc) begin
      dir_mem[di] <= {1'b1, SLOT_W'(counter)};
    end
    if (cmd.dir_read) begin
      dir_rdata <= dir_mem[di];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wipe_step) begin
      table_mem[TAB_AW'({slot, wipe_idx})] <= '0;
    end else if (cmd.finish && !full) begin
      table_mem[TAB_AW'({slot, ti})] <= entry_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dir_index   <= di;
      table_index <= ti;
      table_addr  <= full ? '0 : ((pool_base + slot_offset) & PAGE_MASK);
      new_table   <= fresh;
      entry_value <= full ? '0 : entry_val;
      tables_used <= USED_W'(counter);
      pool_full   <= full;
    end
  end

endmodule

`default_nettype wire

// ===== design/two_level_page_table_mapper.sv =====
// A request passes the lookup, decision, optional wipe and done states before out_valid rises.
// Requests are worked on one at a time; allocating a new table adds a wipe of its 1024 entries.
// The single-write-port table store clears one entry a cycle during that wipe.
// Reset: synchronous, active high; afterwards a pass clears all 1024 directory entries
// while in_ready stays low. Configuration writes are taken throughout.
`default_nettype none

module two_level_page_table_mapper #(
  parameter int MAX_TABLES = tlptm_pkg::MAX_TABLES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tlptm_pkg::ADDR_W-1:0]      cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [tlptm_pkg::ADDR_W-1:0]      virt_addr,
  input  wire logic [tlptm_pkg::ADDR_W-1:0]      phys_addr,
  input  wire logic [tlptm_pkg::FLAG_W-1:0]      entry_flags,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [tlptm_pkg::IDX_W-1:0]            dir_index,
  output logic [tlptm_pkg::IDX_W-1:0]            table_index,
  output logic [tlptm_pkg::ADDR_W-1:0]           table_addr,
  output logic                                   new_table,
  output logic [tlptm_pkg::ADDR_W-1:0]           entry_value,
  output logic [tlptm_pkg::USED_W-1:0]           tables_used,
  output logic                                   pool_full
);
  import tlptm_pkg::*;

  // The pool base register can be written at any time; the contract keeps
  // such writes to moments when no request is in flight.
  assign cfg_ready = 1'b1;

  cmd_t    cmd;
  status_t st;

  // The controller sequences each request: directory read, decision,
  // optional wipe of a fresh table, then the table write together with the
  // load of the output register. Because the result sits in its own
  // register, a new request can be accepted while the previous result is
  // still waiting to be taken.
  tlptm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the directory memory, the table store, the bump
  // allocator's counter and the output register.
  tlptm_datapath #(
    .MAX_TABLES (MAX_TABLES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .virt_addr   (virt_addr),
    .phys_addr   (phys_addr),
    .entry_flags (entry_flags),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .dir_index   (dir_index),
    .table_index (table_index),
    .table_addr  (table_addr),
    .new_table   (new_table),
    .entry_value (entry_value),
    .tables_used (tables_used),
    .pool_full   (pool_full)
  );

  // Only one request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another was in flight");

  // The decision always acts on a directory read made the cycle before.
  a_decide_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> $past(cmd.dir_read))
    else $error("directory decision without a preceding read");

  // An exhausted pool writes nothing, so the reported entry fields are zero.
  a_full_reports_nothing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pool_full) |->
      (!new_table && table_addr == '0 && entry_value == '0))
    else $error("pool-full result carries a table entry");

endmodule

`default_nettype wire
